[rtl/quadrature_pulse_speed_counter_macros.svh]
// ----------------------------------------------------------------------------
// Quadrature pulse speed counter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_PULSE_SPEED_COUNTER_MACROS_SVH
`define QUADRATURE_PULSE_SPEED_COUNTER_MACROS_SVH

// check a condition on every clock edge
`define QPSC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// check a consequent in the same cycle as its antecedent
`define QPSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequent in the cycle after its antecedent
`define QPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qpsc_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrature pulse speed counter package
// Shared widths, codes and the result bundle.
// ----------------------------------------------------------------------------
package qpsc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int WIN_W      = 16;
    localparam int OUT_W      = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(500);

    typedef enum logic [0:0] {
        REG_WINDOW = 1'b0
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_FWD     = 2'd1,
        DIR_REV     = 2'd2
    } t_dir;

    typedef struct packed {
        logic [OUT_W-1:0]        pulse_total;
        t_dir                    rotation;
        logic signed [OUT_W-1:0] pulse_rate;
    } t_result;

endpackage

[rtl/qpsc_core.sv]
// ----------------------------------------------------------------------------
// Quadrature pulse speed counter core
// Holds the encoder tracking state and computes the result of one tick.
// ----------------------------------------------------------------------------
module qpsc_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_chan_a,
    input  logic                     i_chan_b,
    input  logic [qpsc_pkg::WIN_W-1:0] i_window_ticks,
    output qpsc_pkg::t_result        o_next
);
    import qpsc_pkg::*;

    logic                  r_prev_a;
    logic                  r_prev_b;
    logic                  r_primed;
    t_dir                  r_dir;
    t_dir                  r_dir_rem;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [WIN_W-1:0]      r_tick;
    logic [COUNT_BITS-1:0] r_wstart;
    logic [COUNT_BITS-1:0] r_rate;

    t_dir                  n_dir;
    t_dir                  n_dir_rem;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [WIN_W-1:0]      n_tick;
    logic [COUNT_BITS-1:0] n_wstart;
    logic [COUNT_BITS-1:0] n_rate;
    logic [WIN_W-1:0]      tick_inc;
    logic                  changed;

    always_comb begin
        n_dir     = r_dir;
        n_dir_rem = r_dir_rem;
        n_cnt     = r_cnt;
        n_tick    = r_tick;
        n_wstart  = r_wstart;
        n_rate    = r_rate;
        changed   = (i_chan_a != r_prev_a) || (i_chan_b != r_prev_b);
        tick_inc  = r_tick + WIN_W'(1);
        if (r_primed) begin
            if (changed) begin
                n_cnt = r_cnt + COUNT_BITS'(1);
            end
            if (r_prev_a == r_prev_b) begin
                if (!r_prev_a && i_chan_a) begin
                    n_dir = DIR_FWD;
                end else if (!r_prev_b && i_chan_b) begin
                    n_dir = DIR_REV;
                end
            end else if (r_dir != r_dir_rem) begin
                n_cnt     = '0;
                n_dir_rem = r_dir;
            end
            n_tick = tick_inc;
            if (tick_inc >= i_window_ticks) begin
                n_tick   = '0;
                n_rate   = n_cnt - r_wstart;
                n_wstart = n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a  <= 1'b0;
            r_prev_b  <= 1'b0;
            r_primed  <= 1'b0;
            r_dir     <= DIR_UNKNOWN;
            r_dir_rem <= DIR_UNKNOWN;
            r_cnt     <= '0;
            r_tick    <= '0;
            r_wstart  <= '0;
            r_rate    <= '0;
        end else if (i_fire) begin
            r_prev_a  <= i_chan_a;
            r_prev_b  <= i_chan_b;
            r_primed  <= 1'b1;
            r_dir     <= n_dir;
            r_dir_rem <= n_dir_rem;
            r_cnt     <= n_cnt;
            r_tick    <= n_tick;
            r_wstart  <= n_wstart;
            r_rate    <= n_rate;
        end
    end

    assign o_next.pulse_total = OUT_W'(n_cnt);
    assign o_next.rotation    = n_dir;
    assign o_next.pulse_rate  = OUT_W'(n_rate);

`include "quadrature_pulse_speed_counter_macros.svh"

    `QPSC_ASSERT_NEXT(a_cnt_step, i_fire, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + COUNT_BITS'(1)) || (r_cnt == '0), "pulse count moved by more than one")
    `QPSC_ASSERT_NEXT(a_hold_idle, !i_fire, $stable(r_cnt) && $stable(r_tick) && $stable(r_dir), "state changed without a tick")
    `QPSC_ASSERT_SAME(a_rem_clears, r_dir_rem != $past(r_dir_rem), r_cnt == '0, "direction remembered without clearing the count")

endmodule

[rtl/quadrature_pulse_speed_counter.sv]
// ----------------------------------------------------------------------------
// Quadrature pulse speed counter
// Counts encoder edges, tracks direction and measures pulses per window.
//
//   channel  direction  signals
//   in       sink       i_in_valid, o_in_stall, i_chan_a, i_chan_b
//   out      source     o_out_valid, i_out_stall, o_pulse_total, o_rotation,
//                       o_pulse_rate
//   cfg      APB slave  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One tick per cycle unless an output stall holds the input; a tick passes
// one input register and then one result register around the core.
// Reset is synchronous; window_ticks resets to 500.
// An output stall holds the result register and stalls input once it is full.
// ----------------------------------------------------------------------------
module quadrature_pulse_speed_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_chan_a,
    input  logic                        i_chan_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [qpsc_pkg::OUT_W-1:0]  o_pulse_total,
    output logic [1:0]                  o_rotation,
    output logic signed [qpsc_pkg::OUT_W-1:0] o_pulse_rate,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qpsc_pkg::ADDR_W-1:0] paddr,
    input  logic [qpsc_pkg::DATA_W-1:0] pwdata,
    output logic [qpsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import qpsc_pkg::*;

    logic [WIN_W-1:0] r_window_ticks;
    logic             r_in_valid;
    logic             r_in_a;
    logic             r_in_b;
    logic             r_out_valid;
    t_result          r_result;
    t_result          next_result;
    logic             advance;
    logic             fire;
    t_reg_idx         reg_idx;

    assign reg_idx  = t_reg_idx'(paddr[ADDR_W-1]);
    assign pready   = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_WINDOW: prdata = DATA_W'(r_window_ticks);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_RESET;
        end else if (psel && penable && pwrite && reg_idx == REG_WINDOW) begin
            r_window_ticks <= pwdata[WIN_W-1:0];
        end
    end

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_a <= i_chan_a;
            r_in_b <= i_chan_b;
        end
    end

    qpsc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_chan_a       (r_in_a),
        .i_chan_b       (r_in_b),
        .i_window_ticks (r_window_ticks),
        .o_next         (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= next_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pulse_total = r_result.pulse_total;
    assign o_rotation    = r_result.rotation;
    assign o_pulse_rate  = r_result.pulse_rate;

`include "quadrature_pulse_speed_counter_macros.svh"

    `QPSC_ASSERT_ALWAYS(a_stall_full, !o_in_stall || r_in_valid, "input stalled while empty")
    `QPSC_ASSERT_NEXT(a_fire_out, fire, r_out_valid, "processed tick did not reach the output")
    `QPSC_ASSERT_NEXT(a_hold_in, o_in_stall, r_in_valid && $stable(r_in_a) && $stable(r_in_b), "held tick was lost")

endmodule

[tb/quadrature_pulse_speed_counter_tb.sv]
// ----------------------------------------------------------------------------
// Quadrature pulse speed counter testbench
// Drives encoder level ticks with random gaps and output stalls, predicts
// pulse total, rotation and window rate per tick, and checks every result
// in order. Covers the first-tick latch, direction clears, forward priority,
// window sizes from zero to full scale, masked and unmapped register writes.
// ----------------------------------------------------------------------------
module quadrature_pulse_speed_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qpsc_pkg::*;

    localparam int MAX_WAIT     = 10;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 1100;
    localparam logic [ADDR_W-1:0] WINDOW_ADDR   = ADDR_W'(4 * int'(REG_WINDOW));
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4 * (int'(REG_WINDOW) + 1));

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_chan_a;
    logic                     i_chan_b;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [OUT_W-1:0]         o_pulse_total;
    logic [1:0]               o_rotation;
    logic signed [OUT_W-1:0]  o_pulse_rate;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    // encoder state as the block should hold it
    logic                     seen_first   = 1'b0;
    logic                     last_a       = 1'b0;
    logic                     last_b       = 1'b0;
    t_dir                     spin_dir     = DIR_UNKNOWN;
    t_dir                     spin_kept    = DIR_UNKNOWN;
    logic [COUNT_BITS-1:0]    edge_count   = '0;
    logic [COUNT_BITS-1:0]    window_base  = '0;
    logic [COUNT_BITS-1:0]    window_delta = '0;
    logic [WIN_W-1:0]         tick_count   = '0;
    logic [WIN_W-1:0]         window_len   = WINDOW_RESET;

    t_result                  expected_ticks[$];
    logic [1:0]               levels   = 2'b00;
    logic                     in_gaps  = 1'b1;
    logic                     out_gaps = 1'b1;
    int                       errors          = 0;
    int                       ticks_sent      = 0;
    int                       results_checked = 0;
    int                       dir_clears      = 0;
    int                       window_closes   = 0;
    int                       window_writes   = 0;
    int                       quiet_cycles    = 0;

    quadrature_pulse_speed_counter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_chan_a      (i_chan_a),
        .i_chan_b      (i_chan_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pulse_total (o_pulse_total),
        .o_rotation    (o_rotation),
        .o_pulse_rate  (o_pulse_rate),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait(input logic enabled);
        return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    // next level pair of a clean quadrature step, {a, b}
    function automatic logic [1:0] gray_step(input logic fwd, input logic [1:0] ab);
        logic [1:0] nxt;
        case (ab)
            2'b00: nxt = fwd ? 2'b10 : 2'b01;
            2'b10: nxt = fwd ? 2'b11 : 2'b00;
            2'b11: nxt = fwd ? 2'b01 : 2'b10;
            default: nxt = fwd ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    function automatic t_result predict_encoder_tick(input logic a, input logic b);
        t_result res;
        if (!seen_first) begin
            last_a     = a;
            last_b     = b;
            seen_first = 1'b1;
        end else begin
            if (a != last_a || b != last_b) begin
                edge_count = edge_count + COUNT_BITS'(1);
            end
            if (last_a == last_b) begin
                if (!last_a && a) begin
                    spin_dir = DIR_FWD;
                end else if (!last_b && b) begin
                    spin_dir = DIR_REV;
                end
            end else if (spin_dir != spin_kept) begin
                edge_count = '0;
                spin_kept  = spin_dir;
                dir_clears++;
            end
            last_a     = a;
            last_b     = b;
            tick_count = tick_count + WIN_W'(1);
            if (tick_count >= window_len) begin
                tick_count   = '0;
                window_delta = edge_count - window_base;
                window_base  = edge_count;
                window_closes++;
            end
        end
        res.pulse_total = edge_count[OUT_W-1:0];
        res.rotation    = spin_dir;
        res.pulse_rate  = signed'(window_delta[OUT_W-1:0]);
        return res;
    endfunction

    task automatic send_tick(input logic [1:0] ab);
        int gap;
        gap = draw_wait(in_gaps);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_chan_a   = ab[1];
        i_chan_b   = ab[0];
        do @(posedge i_clk); while (o_in_stall);
        expected_ticks.push_back(predict_encoder_tick(ab[1], ab[0]));
        levels = ab;
        ticks_sent++;
    endtask

    // drop valid and wait for every pending result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data,
                              output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_window();
        logic [DATA_W-1:0] readback;
        apb_access(1'b0, WINDOW_ADDR, '0, readback);
        if (readback[WIN_W-1:0] !== window_len) begin
            errors++;
            $display("%0t: window_ticks read expected %0d actual %0d",
                     $time, window_len, readback[WIN_W-1:0]);
        end
    endtask

    task automatic write_window(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] unused;
        settle();
        apb_access(1'b1, addr, value, unused);
        if (addr == WINDOW_ADDR) begin
            window_len = value[WIN_W-1:0];
            window_writes++;
        end
        check_window();
    endtask

    task automatic test_first_tick_and_direction();
        logic [1:0] steps[] = '{2'b11, 2'b11, 2'b00, 2'b11, 2'b01, 2'b00, 2'b01,
                                2'b11, 2'b10, 2'b00, 2'b10, 2'b11, 2'b01, 2'b00};
        check_window();
        foreach (steps[i]) send_tick(steps[i]);
    endtask

    task automatic test_window_limits();
        write_window(WINDOW_ADDR, 32'hFFFF_0001);
        repeat (4) send_tick(gray_step(1'b1, levels));
        write_window(WINDOW_ADDR, 32'h0000_0000);
        repeat (3) send_tick(gray_step(1'b0, levels));
        write_window(UNMAPPED_ADDR, 32'h0000_0007);
        repeat (2) send_tick(gray_step(1'b0, levels));
        write_window(WINDOW_ADDR, 32'h0000_FFFF);
        repeat (4) send_tick(gray_step(1'b1, levels));
        write_window(WINDOW_ADDR, 32'h0000_0003);
        repeat (3) send_tick(gray_step(1'b1, levels));
    endtask

    task automatic test_random_traffic();
        logic [WIN_W-1:0] windows[] = '{16'd2, 16'd1, 16'd7, 16'd64, 16'd500,
                                        16'd65535, 16'd13};
        logic [1:0]       next_ab;
        int               per_phase;
        int               sent;
        int               kind;
        int               run_len;
        per_phase = RANDOM_TICKS / windows.size();
        foreach (windows[w]) begin
            write_window(WINDOW_ADDR, {16'($urandom), windows[w]});
            sent = 0;
            while (sent < per_phase) begin
                kind     = $urandom_range(0, 9);
                run_len  = $urandom_range(1, 30);
                in_gaps  = ($urandom_range(0, 2) != 0);
                out_gaps = ($urandom_range(0, 2) != 0);
                repeat (run_len) begin
                    if (sent < per_phase) begin
                        if (kind >= 8) begin
                            next_ab = 2'($urandom);
                        end else if (kind == 7 || $urandom_range(0, 3) == 0) begin
                            next_ab = levels;
                        end else begin
                            next_ab = gray_step(kind < 4, levels);
                        end
                        send_tick(next_ab);
                        sent++;
                    end
                end
            end
        end
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
    endtask

    initial begin : drive_out_stall
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = draw_wait(out_gaps);
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: result with no tick pending: total %0d rotation %0d rate %0d",
                         $time, o_pulse_total, o_rotation, o_pulse_rate);
            end else begin
                want = expected_ticks.pop_front();
                results_checked++;
                if (o_pulse_total !== want.pulse_total) begin
                    errors++;
                    $display("%0t: pulse_total expected %0d actual %0d",
                             $time, want.pulse_total, o_pulse_total);
                end
                if (o_rotation !== want.rotation) begin
                    errors++;
                    $display("%0t: rotation expected %0d actual %0d",
                             $time, want.rotation, o_rotation);
                end
                if (o_pulse_rate !== want.pulse_rate) begin
                    errors++;
                    $display("%0t: pulse_rate expected %0d actual %0d",
                             $time, want.pulse_rate, o_pulse_rate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("** quadrature_pulse_speed_counter: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_chan_a   = 1'b0;
        i_chan_b   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_tick_and_direction();
        test_window_limits();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);
        if (expected_ticks.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_ticks.size());
        end
        $display("Sent %0d ticks across %0d window settings, checked %0d results.",
                 ticks_sent, window_writes, results_checked);
        $display("Saw %0d direction clears and %0d closed windows.", dir_clears, window_closes);
        if (errors == 0) begin
            $display("** quadrature_pulse_speed_counter: PASSED **");
        end else begin
            $display("** quadrature_pulse_speed_counter: FAILED **");
        end
        $finish;
    end

endmodule
